// ===== rtl/xchf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xchf_pkg
// Shared types, constants and helpers for the XOR-checked hex ASCII framer.
// ----------------------------------------------------------------------------
package xchf_pkg;

    localparam int unsigned ByteW     = 8;
    localparam int unsigned CharW     = 7;
    localparam int unsigned NibbleW   = 4;
    localparam int unsigned MaxBytes  = 4;   // start, length, data, checksum
    localparam int unsigned CharIdxW  = 3;   // up to 8 characters per word

    localparam logic [ByteW-1:0]   StartByteReset = 8'hAA;
    localparam logic [CharW-1:0]   AsciiZero      = 7'h30;
    localparam logic [CharW-1:0]   AsciiUpperA    = 7'h41;
    localparam logic [NibbleW-1:0] NibbleTen      = 4'd10;

    // Character index of the last character for each frame shape
    localparam logic [CharIdxW-1:0] LastIdxData      = 3'd1;
    localparam logic [CharIdxW-1:0] LastIdxDataChk   = 3'd3;
    localparam logic [CharIdxW-1:0] LastIdxHdrData   = 3'd5;
    localparam logic [CharIdxW-1:0] LastIdxHdrDataCk = 3'd7;

    // Bytes to be sent as hex for one accepted input word, lowest index first
    typedef struct packed {
        logic [MaxBytes-1:0][ByteW-1:0] bytes;
        logic [CharIdxW-1:0]            last_idx;
        logic                           eop;
    } bundle_t;

    function automatic logic [CharW-1:0] hex_ascii(input logic [NibbleW-1:0] nib);
        logic [CharW-1:0] ext;
        ext = {3'b000, nib};
        if (nib < NibbleTen) begin
            hex_ascii = AsciiZero + ext;
        end else begin
            hex_ascii = AsciiUpperA + (ext - {3'b000, NibbleTen});
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/xchf_framer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xchf_framer
// Packet state, length and checksum tracking; builds the byte bundle for
// each accepted payload word.
// ----------------------------------------------------------------------------
module xchf_framer (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [7:0]             cfg_wr_data,
    input  wire logic                   accept,
    input  wire logic [7:0]             data_byte,
    input  wire logic [7:0]             payload_length,
    output xchf_pkg::bundle_t           bundle
);

    logic [7:0] frame_mark_reg;
    logic       in_packet_reg;
    logic [7:0] bytes_left_reg;
    logic [7:0] checksum_reg;

    logic [7:0] len;
    logic [7:0] left_next;
    logic [7:0] sum_base;
    logic [7:0] chk;
    logic       done;

    always_comb begin
        len       = (payload_length == 8'd0) ? 8'd1 : payload_length;
        left_next = (in_packet_reg ? bytes_left_reg : len) - 8'd1;
        sum_base  = in_packet_reg ? checksum_reg : (frame_mark_reg ^ len);
        chk       = sum_base ^ data_byte;
        done      = (left_next == 8'd0);

        bundle.eop = done;
        if (!in_packet_reg) begin
            bundle.bytes    = {chk, data_byte, len, frame_mark_reg};
            bundle.last_idx = done ? xchf_pkg::LastIdxHdrDataCk : xchf_pkg::LastIdxHdrData;
        end else begin
            bundle.bytes    = {8'h00, 8'h00, chk, data_byte};
            bundle.last_idx = done ? xchf_pkg::LastIdxDataChk : xchf_pkg::LastIdxData;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_mark_reg <= xchf_pkg::StartByteReset;
            in_packet_reg  <= 1'b0;
            bytes_left_reg <= 8'd0;
            checksum_reg   <= 8'd0;
        end else begin
            if (cfg_wr_en) begin
                frame_mark_reg <= cfg_wr_data;
            end
            if (accept) begin
                in_packet_reg  <= !done;
                bytes_left_reg <= left_next;
                checksum_reg   <= done ? 8'd0 : chk;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/xchf_serializer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xchf_serializer
// Holds one byte bundle and sends it one hex character per cycle, while the
// output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module xchf_serializer (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load,
    input  wire xchf_pkg::bundle_t  bundle,
    output logic                    load_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [6:0]              out_char,
    output logic                    out_last
);

    xchf_pkg::bundle_t bnd_reg;
    logic              bnd_valid_reg;
    logic [2:0]        idx_reg;
    logic              out_valid_reg;
    logic [6:0]        out_char_reg;
    logic              out_last_reg;

    logic       out_free;
    logic       move;
    logic       bnd_done;
    logic [7:0] cur_byte;
    logic [3:0] cur_nib;

    always_comb begin
        out_free   = !out_valid_reg || out_ready;
        move       = bnd_valid_reg && out_free;
        bnd_done   = move && (idx_reg == bnd_reg.last_idx);
        load_ready = !bnd_valid_reg || bnd_done;
        cur_byte   = bnd_reg.bytes[idx_reg[2:1]];
        // high nibble first
        cur_nib    = idx_reg[0] ? cur_byte[3:0] : cur_byte[7:4];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bnd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end else begin
            if (load) begin
                bnd_valid_reg <= 1'b1;
                idx_reg       <= 3'd0;
            end else if (bnd_done) begin
                bnd_valid_reg <= 1'b0;
            end else if (move) begin
                idx_reg <= idx_reg + 3'd1;
            end
            if (out_free) begin
                out_valid_reg <= bnd_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bnd_reg <= bundle;
        end
        if (move) begin
            out_char_reg <= xchf_pkg::hex_ascii(cur_nib);
            out_last_reg <= bnd_reg.eop && (idx_reg == bnd_reg.last_idx);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule
`default_nettype wire

// ===== rtl/xor_checked_hex_ascii_framer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xor_checked_hex_ascii_framer
// Frames payload bytes as uppercase hex ASCII with an XOR checksum.
// ----------------------------------------------------------------------------
// Each input word carries one payload byte; the length is taken from the first
// word of a packet (zero counts as one). The first word of a packet produces
// the start byte and length as four characters ahead of its own two; the last
// word appends two checksum characters (XOR of start, length and payload), the
// final one flagged with tlast. So a word yields 2, 4, 6 or 8 characters, one
// per cycle on the output while m_axis_tready holds; a word is taken while the
// previous one is still being sent, so sustained throughput for payload bytes
// is set by the single character output lane. A write of the start marker
// applies from the next packet on.
module xor_checked_hex_ascii_framer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,     // start marker byte
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,    // [7:0] data_byte, [15:8] payload_length
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,    // [6:0] hex_char, [7] zero
    output logic             m_axis_tlast     // end_of_packet
);

    xchf_pkg::bundle_t bundle;
    logic              accept;
    logic              load_ready;
    logic [6:0]        hex_char;

    assign s_axis_tready = load_ready;
    assign accept        = s_axis_tvalid && load_ready;

    xchf_framer u_framer (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .accept         (accept),
        .data_byte      (s_axis_tdata[7:0]),
        .payload_length (s_axis_tdata[15:8]),
        .bundle         (bundle)
    );

    xchf_serializer u_serializer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept),
        .bundle     (bundle),
        .load_ready (load_ready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_char   (hex_char),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, hex_char};

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: xor_checked_hex_ascii_framer testbench
// Feeds payload words through a randomly stalling stream and checks every
// hex character and end-of-packet flag against a cycle-free frame predictor.
// Start byte settings change between phases, sometimes in the middle of a
// packet. One phase keeps the output stalled for a long stretch while a
// long packet is offered back to back.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned CycleLimit = 300000;
    localparam int unsigned TailCycles = 16;
    localparam int unsigned HoldCycles = 400;
    localparam int unsigned RandItems  = 150;
    localparam int unsigned LongLen    = 100;

    typedef struct {
        logic [7:0] data_byte;
        logic [7:0] payload_length;
    } payload_word_t;

    typedef struct {
        logic [xchf_pkg::CharW-1:0] hex_char;
        logic                       end_of_packet;
    } frame_char_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [7:0]  cfg_wr_data   = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = 16'h0000;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    xor_checked_hex_ascii_framer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    payload_word_t pending_words[$];
    frame_char_t   frame_chars[$];

    // predictor copy of the framer
    logic [7:0]  start_marker = xchf_pkg::StartByteReset;
    logic        pk_open      = 1'b0;
    logic [7:0]  pk_left      = 8'h00;
    logic [7:0]  pk_xor       = 8'h00;

    int unsigned errors       = 0;
    int unsigned cycles       = 0;
    bit          src_calm     = 1'b0;
    bit          sink_calm    = 1'b0;
    bit          sink_hold    = 1'b0;
    bit          hold_go      = 1'b0;
    int unsigned src_wait     = 0;
    int unsigned sink_wait    = 0;

    function automatic logic [xchf_pkg::CharW-1:0] nibble_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return 7'h30 + {3'b000, nib};
        end
        return 7'h41 + {3'b000, nib} - 7'd10;
    endfunction

    task automatic push_byte_chars(input logic [7:0] b, input logic eop);
        frame_chars.push_back('{nibble_char(b[7:4]), 1'b0});
        frame_chars.push_back('{nibble_char(b[3:0]), eop});
    endtask

    task automatic frame_word(input payload_word_t w);
        logic [7:0] len;
        if (!pk_open) begin
            len = (w.payload_length == 8'h00) ? 8'h01 : w.payload_length;
            push_byte_chars(start_marker, 1'b0);
            push_byte_chars(len, 1'b0);
            pk_xor  = start_marker ^ len;
            pk_left = len;
            pk_open = 1'b1;
        end
        push_byte_chars(w.data_byte, 1'b0);
        pk_xor  = pk_xor ^ w.data_byte;
        pk_left = pk_left - 8'd1;
        if (pk_left == 8'h00) begin
            push_byte_chars(pk_xor, 1'b1);
            pk_open = 1'b0;
            pk_xor  = 8'h00;
        end
    endtask

    function automatic int unsigned draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 10);
    endfunction

    // sender: one word per handshake, random gap after each word
    always @(posedge aclk) begin : src_side
        payload_word_t w;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            src_wait      <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                frame_word('{s_axis_tdata[7:0], s_axis_tdata[15:8]});
            end
            if (src_wait != 0) begin
                src_wait      <= src_wait - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                w = pending_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {w.payload_length, w.data_byte};
                src_wait      <= draw_wait(src_calm);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: check each word, then draw the stall before the next one
    always @(posedge aclk) begin : sink_side
        int unsigned nw;
        frame_char_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            sink_wait     <= 0;
        end else begin
            nw = sink_wait;
            if (m_axis_tvalid && m_axis_tready) begin
                if (frame_chars.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("unexpected word: char %h last %b",
                                 m_axis_tdata, m_axis_tlast);
                    end
                end else begin
                    want = frame_chars.pop_front();
                    if (m_axis_tdata !== {1'b0, want.hex_char} ||
                        m_axis_tlast !== want.end_of_packet) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch: char %h last %b, expected char %h last %b",
                                     m_axis_tdata, m_axis_tlast,
                                     {1'b0, want.hex_char}, want.end_of_packet);
                        end
                    end
                end
                nw = draw_wait(sink_calm);
            end else if (nw != 0) begin
                nw--;
            end
            sink_wait     <= nw;
            m_axis_tready <= (nw == 0) && !sink_hold;
        end
    end

    // long output stall, counted here so the sender keeps pushing
    initial begin : long_stall
        wait (hold_go);
        @(posedge aclk);
        sink_hold <= 1'b1;
        repeat (HoldCycles) @(posedge aclk);
        sink_hold <= 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic push_word(input logic [7:0] data, input logic [7:0] len);
        pending_words.push_back('{data, len});
    endtask

    // hold until every word is sent and every character has come back
    task automatic wait_idle();
        do begin
            @(posedge aclk);
        end while (pending_words.size() != 0 || s_axis_tvalid || frame_chars.size() != 0);
        repeat (TailCycles) @(posedge aclk);
    endtask

    task automatic write_start(input logic [7:0] v);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_data  <= v;
        start_marker  = v;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned rand_items;
        int unsigned npk;
        int unsigned len;
        int unsigned n;
        int unsigned pick;
        logic [7:0]  sb;
        logic [7:0]  len_field;

        rand_items = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset start byte: single byte, zero length, ignored length fields
        push_word(8'h00, 8'h01);
        push_word(8'hFF, 8'h00);
        push_word(8'h5A, 8'h03);
        push_word(8'hA5, 8'hFF);
        push_word(8'h0F, 8'h00);
        push_word(8'hF0, 8'h02);
        wait_idle();

        // change the start byte in the middle of a packet
        write_start(8'h00);
        push_word(8'h80, 8'h55);
        push_word(8'h7F, 8'h02);
        push_word(8'h01, 8'h80);
        wait_idle();

        write_start(8'hFF);
        push_word(8'hC3, 8'h01);
        push_word(8'h3C, 8'h04);
        push_word(8'hAA, 8'hAA);
        push_word(8'h55, 8'h55);
        push_word(8'h99, 8'h7F);
        wait_idle();

        // long packet offered back to back against a stalled output
        write_start(8'h3C);
        src_calm = 1'b1;
        hold_go  = 1'b1;
        for (int i = 0; i < LongLen; i++) begin
            push_word(8'($urandom_range(0, 255)),
                      (i == 0) ? 8'(LongLen) : 8'($urandom_range(0, 255)));
        end
        wait_idle();

        while (rand_items < RandItems) begin
            pick = $urandom_range(0, 3);
            sb = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
            write_start(sb);
            src_calm  = ($urandom_range(0, 3) == 0);
            sink_calm = ($urandom_range(0, 3) == 0);
            npk = $urandom_range(1, 6);
            for (int p = 0; p < npk; p++) begin
                pick = $urandom_range(0, 19);
                if (pick < 14) begin
                    len = $urandom_range(1, 4);
                end else if (pick < 19) begin
                    len = $urandom_range(5, 16);
                end else begin
                    len = $urandom_range(17, 40);
                end
                len_field = 8'(len);
                if ($urandom_range(0, 15) == 0) begin
                    len       = 1;
                    len_field = 8'h00;
                end
                n = len;
                // leave the last packet open now and then
                if (p == npk - 1 && len > 1 && $urandom_range(0, 2) == 0) begin
                    n = $urandom_range(1, len - 1);
                end
                for (int i = 0; i < n; i++) begin
                    push_word(8'($urandom_range(0, 255)),
                              (i == 0) ? len_field : 8'($urandom_range(0, 255)));
                end
                rand_items += n;
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/xchf_pkg.sv
rtl/xchf_framer.sv
rtl/xchf_serializer.sv
rtl/xor_checked_hex_ascii_framer.sv
verif/tb.sv
